// ----- design/chd_pkg.sv -----
// ============================================================================
// Cartridge header decoder package
// Shared widths, header offsets and the decode functions for the cartridge
// type, ROM size and RAM size codes.
// ============================================================================
`default_nettype none

package chd_pkg;

    // Field widths.
    localparam int unsigned ADDR_W    = 14;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned IN_DATA_W = 24;
    localparam int unsigned OUT_DATA_W = 80;

    // Size of the first ROM bank; bytes at or beyond it are dropped.
    localparam int unsigned BANK_BYTES = 16384;

    // Header offsets.
    localparam logic [ADDR_W-1:0] HDR_FIRST      = 14'h143;
    localparam logic [ADDR_W-1:0] HDR_FINAL      = 14'h14F;
    localparam int unsigned       HDR_DEPTH      = 12;
    localparam int unsigned       HDR_IDX_W      = 4;

    // Slots of the captured header, counted from offset 0x143.
    localparam logic [HDR_IDX_W-1:0] IDX_CGB     = 4'd0;  // 0x143
    localparam logic [HDR_IDX_W-1:0] IDX_NEWLIC_HI = 4'd1; // 0x144
    localparam logic [HDR_IDX_W-1:0] IDX_NEWLIC_LO = 4'd2; // 0x145
    localparam logic [HDR_IDX_W-1:0] IDX_SGB     = 4'd3;  // 0x146
    localparam logic [HDR_IDX_W-1:0] IDX_TYPE    = 4'd4;  // 0x147
    localparam logic [HDR_IDX_W-1:0] IDX_ROM     = 4'd5;  // 0x148
    localparam logic [HDR_IDX_W-1:0] IDX_RAM     = 4'd6;  // 0x149
    localparam logic [HDR_IDX_W-1:0] IDX_DEST    = 4'd7;  // 0x14A
    localparam logic [HDR_IDX_W-1:0] IDX_OLDLIC  = 4'd8;  // 0x14B
    localparam logic [HDR_IDX_W-1:0] IDX_VERSION = 4'd9;  // 0x14C
    localparam logic [HDR_IDX_W-1:0] IDX_HSUM    = 4'd10; // 0x14D
    localparam logic [HDR_IDX_W-1:0] IDX_GSUM_HI = 4'd11; // 0x14E

    // Marker values.
    localparam logic [7:0] COLOR_MARK  = 8'h80;
    localparam logic [7:0] NEWLIC_MARK = 8'h33;
    localparam logic [7:0] SUPER_MARK  = 8'h03;
    localparam logic [7:0] JAPAN_MARK  = 8'h00;

    // Mapper kinds.
    localparam logic [2:0] MAP_NONE = 3'd0;
    localparam logic [2:0] MAP_MBC1 = 3'd1;
    localparam logic [2:0] MAP_MBC2 = 3'd2;
    localparam logic [2:0] MAP_MBC3 = 3'd3;
    localparam logic [2:0] MAP_MBC5 = 3'd4;

    // Feature flags.
    localparam logic [3:0] F_RAM = 4'b0001;
    localparam logic [3:0] F_BAT = 4'b0010;
    localparam logic [3:0] F_TIM = 4'b0100;
    localparam logic [3:0] F_RUM = 4'b1000;

    // Error codes.
    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_TYPE = 2'd1;
    localparam logic [1:0] ERR_ROM  = 2'd2;
    localparam logic [1:0] ERR_RAM  = 2'd3;

    typedef struct packed {
        logic       ok;
        logic [2:0] mapper;
        logic [3:0] feat;
    } t_type_dec;

    typedef struct packed {
        logic [2:0]  mapper_kind;
        logic [3:0]  feature_bits;
        logic [7:0]  rom_bank_total;
        logic [4:0]  ram_bank_total;
        logic [2:0]  platform_bits;
        logic [15:0] licensee;
        logic [7:0]  rom_version;
        logic [7:0]  header_sum;
        logic [15:0] global_sum;
        logic [1:0]  error_code;
    } t_result;

    function automatic t_type_dec decode_type(input logic [7:0] code);
        t_type_dec d;
        d = '{ok: 1'b1, mapper: MAP_NONE, feat: 4'd0};
        case (code)
            8'h00: d.mapper = MAP_NONE;
            8'h01: d.mapper = MAP_MBC1;
            8'h02: begin d.mapper = MAP_MBC1; d.feat = F_RAM; end
            8'h03: begin d.mapper = MAP_MBC1; d.feat = F_RAM | F_BAT; end
            8'h05: d.mapper = MAP_MBC2;
            8'h06: begin d.mapper = MAP_MBC2; d.feat = F_BAT; end
            8'h08: d.feat = F_RAM;
            8'h09: d.feat = F_RAM | F_BAT;
            8'h0F: begin d.mapper = MAP_MBC3; d.feat = F_TIM | F_BAT; end
            8'h10: begin d.mapper = MAP_MBC3; d.feat = F_TIM | F_RAM | F_BAT; end
            8'h11: d.mapper = MAP_MBC3;
            8'h12: begin d.mapper = MAP_MBC3; d.feat = F_RAM; end
            8'h13: begin d.mapper = MAP_MBC3; d.feat = F_RAM | F_BAT; end
            8'h19: d.mapper = MAP_MBC5;
            8'h1A: begin d.mapper = MAP_MBC5; d.feat = F_RAM; end
            8'h1B: begin d.mapper = MAP_MBC5; d.feat = F_RAM | F_BAT; end
            8'h1C: begin d.mapper = MAP_MBC5; d.feat = F_RUM; end
            8'h1D: begin d.mapper = MAP_MBC5; d.feat = F_RUM | F_RAM; end
            8'h1E: begin d.mapper = MAP_MBC5; d.feat = F_RUM | F_RAM | F_BAT; end
            default: d = '{ok: 1'b0, mapper: MAP_NONE, feat: 4'd0};
        endcase
        return d;
    endfunction

    // Zero means the code is not a valid ROM size.
    function automatic logic [7:0] decode_rom(input logic [7:0] code);
        logic [7:0] banks;
        case (code)
            8'h00:   banks = 8'd2;
            8'h01:   banks = 8'd4;
            8'h02:   banks = 8'd8;
            8'h03:   banks = 8'd16;
            8'h04:   banks = 8'd32;
            8'h05:   banks = 8'd64;
            8'h06:   banks = 8'd128;
            8'h52:   banks = 8'd72;
            8'h53:   banks = 8'd80;
            8'h54:   banks = 8'd96;
            default: banks = 8'd0;
        endcase
        return banks;
    endfunction

    // Bit 5 flags an invalid RAM size code; bits 4:0 carry the bank count.
    function automatic logic [5:0] decode_ram(input logic [7:0] code);
        logic [5:0] r;
        case (code)
            8'h00:   r = 6'd0;
            8'h01:   r = 6'd1;
            8'h02:   r = 6'd1;
            8'h03:   r = 6'd4;
            8'h04:   r = 6'd16;
            default: r = 6'b100000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/cartridge_header_decoder_unit.sv -----
// ============================================================================
// Cartridge header decoder
// Captures the cartridge header from a stream of first-bank ROM bytes and
// emits one decoded header transaction when the byte at offset 0x14F arrives.
// ============================================================================
`default_nettype none

// Each input transaction carries one ROM byte and its offset in the first bank.
// Bytes at offsets 0x143 through 0x14E are kept in a small header register
// file; all other offsets are dropped, except 0x14F, which triggers one output
// transaction with the mapper kind, feature flags, ROM and RAM bank counts,
// platform flags, licensee, version and both stored checksums. Header bytes
// never sent read as zero. Unknown type, ROM size or RAM size codes are
// reported in the error code, the first of them in that order winning. The
// block is a two-register pipeline: an input register, then the table decode
// into the output register. It takes one transaction every cycle unless a
// stalled output has filled the input register. The decoded header is offered
// on the output side once the 0x14F byte has passed the input register and
// the decode into the output register; a stalled output holds its data and
// stalls the input side only once the input register is also occupied.
module cartridge_header_decoder_unit
    import chd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input stream.
    input  wire logic                  s_axis_tvalid,
    output      logic                  s_axis_tready,
    // tdata, from bit 0: byte_address[13:0], rom_byte[7:0], 2 zero bits.
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Output stream.
    output      logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata, from bit 0: mapper_kind[2:0], feature_bits[3:0],
    // rom_bank_total[7:0], ram_bank_total[4:0], platform_bits[2:0],
    // licensee[15:0], rom_version[7:0], header_sum[7:0], global_sum[15:0],
    // error_code[1:0], 7 zero bits.
    output      logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // Input register stage.
    logic              r_in_valid;
    logic [ADDR_W-1:0] r_in_addr;
    logic [BYTE_W-1:0] r_in_byte;

    // Captured header bytes, offsets 0x143..0x14E.
    logic [BYTE_W-1:0] r_hdr [HDR_DEPTH];

    // Output register stage.
    logic    r_out_valid;
    t_result r_out;

    logic    in_fire;
    logic    stage_adv;
    logic    in_bank;
    logic    is_final;
    logic [ADDR_W-1:0] hdr_off;

    t_type_dec  type_dec;
    logic [7:0] rom_count;
    logic [5:0] ram_dec;
    logic       old_is_new;
    t_result    n_out;

    // The output register accepts a new result when it is empty or draining.
    assign stage_adv     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || stage_adv;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Every address fits the 14-bit field, but the bank limit is kept explicit.
    assign in_bank  = 32'(r_in_addr) < BANK_BYTES;
    assign is_final = in_bank && (r_in_addr == HDR_FINAL);
    assign hdr_off  = r_in_addr - HDR_FIRST;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (in_fire) begin
            r_in_addr <= s_axis_tdata[ADDR_W-1:0];
            r_in_byte <= s_axis_tdata[ADDR_W +: BYTE_W];
        end
    end

    // Header bytes are written as their transaction leaves the input register,
    // so a 0x14F byte behind them in the stream always sees them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HDR_DEPTH; i++) begin
                r_hdr[i] <= '0;
            end
        end else if (r_in_valid && stage_adv && in_bank
                     && (hdr_off < ADDR_W'(HDR_DEPTH))) begin
            r_hdr[hdr_off[HDR_IDX_W-1:0]] <= r_in_byte;
        end
    end

    // Header decode.
    always_comb begin
        type_dec   = decode_type(r_hdr[IDX_TYPE]);
        rom_count  = decode_rom(r_hdr[IDX_ROM]);
        ram_dec    = decode_ram(r_hdr[IDX_RAM]);
        old_is_new = (r_hdr[IDX_OLDLIC] == NEWLIC_MARK);

        n_out.mapper_kind    = type_dec.mapper;
        n_out.feature_bits   = type_dec.feat;
        n_out.rom_bank_total = rom_count;
        n_out.ram_bank_total = ram_dec[4:0];
        n_out.platform_bits  = {r_hdr[IDX_DEST] == JAPAN_MARK,
                                (r_hdr[IDX_SGB] == SUPER_MARK) && old_is_new,
                                r_hdr[IDX_CGB] == COLOR_MARK};
        n_out.licensee       = old_is_new
                               ? {r_hdr[IDX_NEWLIC_HI], r_hdr[IDX_NEWLIC_LO]}
                               : {8'd0, r_hdr[IDX_OLDLIC]};
        n_out.rom_version    = r_hdr[IDX_VERSION];
        n_out.header_sum     = r_hdr[IDX_HSUM];
        n_out.global_sum     = {r_hdr[IDX_GSUM_HI], r_in_byte};

        if (!type_dec.ok) begin
            n_out.error_code = ERR_TYPE;
        end else if (rom_count == 8'd0) begin
            n_out.error_code = ERR_ROM;
        end else if (ram_dec[5]) begin
            n_out.error_code = ERR_RAM;
        end else begin
            n_out.error_code = ERR_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_adv) begin
            r_out_valid <= r_in_valid && is_final;
        end
        if (stage_adv && r_in_valid && is_final) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0,
                            r_out.error_code,
                            r_out.global_sum,
                            r_out.header_sum,
                            r_out.rom_version,
                            r_out.licensee,
                            r_out.platform_bits,
                            r_out.ram_bank_total,
                            r_out.rom_bank_total,
                            r_out.feature_bits,
                            r_out.mapper_kind};

endmodule

`default_nettype wire

// ----- design/chd_checker.sv -----
// ============================================================================
// Cartridge header decoder checker
// Port-level assertions on the output stream of the header decoder.
// ============================================================================
`default_nettype none

module chd_checker
    import chd_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // A stalled transaction stays offered.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    // A stalled transaction keeps its data.
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    // Nothing is offered right after reset.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // An unknown type code zeroes the mapper kind and feature flags.
    a_type_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[72:71] == ERR_TYPE)
        |-> (m_axis_tdata[6:0] == 7'd0))
        else $error("type error with nonzero mapper fields");

    // A clean header has a known mapper, a ROM bank count and a bounded RAM count.
    a_ok_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[72:71] == ERR_OK)
        |-> (m_axis_tdata[14:7] != 8'd0) && (m_axis_tdata[2:0] <= MAP_MBC5)
            && (m_axis_tdata[19:15] <= 5'd16))
        else $error("clean header with out-of-range fields");

endmodule

bind cartridge_header_decoder_unit chd_checker u_chd_checker (.*);

`default_nettype wire
